>>> hw/rtl/ppk_pkg.sv
// Shared types and codes for the pixel format packer.
`default_nettype none

package ppk_pkg;

    localparam int WORD_W = 64;
    localparam int TEX_W  = 32;
    localparam int LEN_W  = 6;
    localparam int FILL_W = 6;
    localparam int CFG_W  = 3;
    localparam int IDX_W  = 2;

    localparam int FIFO_DEPTH_DEF = 4;

    // pixel_format codes
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_YUV  = 3'd1;
    localparam logic [2:0] FMT_CI   = 3'd2;
    localparam logic [2:0] FMT_I    = 3'd3;
    localparam logic [2:0] FMT_IA   = 3'd4;

    // pixel_size codes
    localparam logic [1:0] SZ_4B  = 2'd0;
    localparam logic [1:0] SZ_8B  = 2'd1;
    localparam logic [1:0] SZ_16B = 2'd2;
    localparam logic [1:0] SZ_32B = 2'd3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FORMAT   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SIZE     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CHANNELS = 2'd2;

    // one converted texel, right-aligned, plus the end-of-image mark
    typedef struct packed {
        logic [TEX_W-1:0] bits;
        logic [LEN_W-1:0] len;
        logic             last;
    } texel_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppk_front.sv
// Front end: configuration registers and pixel-to-texel conversion.
`default_nettype none

module ppk_front
    import ppk_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic [31:0]      pix,
    input  wire logic             pix_last,
    output texel_t                texel
);

    logic [2:0] format_reg;
    logic [1:0] size_reg;
    logic [2:0] chans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_RGBA;
            size_reg   <= SZ_32B;
            chans_reg  <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORMAT:   format_reg <= cfg_data;
                CFG_SIZE:     size_reg   <= cfg_data[1:0];
                CFG_CHANNELS: chans_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic [7:0]  c0, c1, c2, c3;
    logic [7:0]  r, g, b, a, i;
    logic [15:0] isum;
    logic        colour, gray;

    assign c0 = pix[7:0];
    assign c1 = pix[15:8];
    assign c2 = pix[23:16];
    assign c3 = pix[31:24];

    assign colour = (chans_reg == 3'd3) || (chans_reg == 3'd4);
    assign gray   = (chans_reg == 3'd1) || (chans_reg == 3'd2);
    // max sum is 256*255, fits 16 bits
    assign isum = ({8'd0, c0} * 16'd85) + ({8'd0, c1} * 16'd86) + ({8'd0, c2} * 16'd85);

    always_comb
    begin
        r = 8'd0;
        g = 8'd0;
        b = 8'd1;
        a = 8'hFF;
        i = 8'd0;
        if (chans_reg == 3'd4)
            a = c3;
        if (chans_reg == 3'd2)
            a = c1;
        if (colour)
        begin
            r = c0;
            g = c1;
            b = c2;
            i = isum[15:8];
        end
        if (gray)
        begin
            r = c0;
            g = c0;
            b = c0;
            i = c0;
        end
    end

    always_comb
    begin
        texel.bits = '0;
        texel.len  = '0;
        texel.last = pix_last;
        case (format_reg) inside
            FMT_RGBA:
            begin
                if (size_reg == SZ_32B)
                begin
                    texel.bits = {r, g, b, a};
                    texel.len  = 6'd32;
                end
                else if (size_reg == SZ_16B)
                begin
                    texel.bits = {16'd0, r[7:3], g[7:3], b[7:3], a[7]};
                    texel.len  = 6'd16;
                end
            end
            FMT_CI, FMT_I:
            begin
                if (size_reg == SZ_8B)
                begin
                    texel.bits = {24'd0, i};
                    texel.len  = 6'd8;
                end
                else if (size_reg == SZ_4B)
                begin
                    texel.bits = {28'd0, i[7:4]};
                    texel.len  = 6'd4;
                end
            end
            FMT_IA:
            begin
                if (size_reg == SZ_16B)
                begin
                    texel.bits = {16'd0, i, a};
                    texel.len  = 6'd16;
                end
                else if (size_reg == SZ_8B)
                begin
                    texel.bits = {24'd0, i[7:4], a[7:4]};
                    texel.len  = 6'd8;
                end
                else if (size_reg == SZ_4B)
                begin
                    texel.bits = {28'd0, i[7:5], a[7]};
                    texel.len  = 6'd4;
                end
            end
            default: ; // yuv and unused codes add no bits
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppk_fifo.sv
// Short texel queue between the converter and the packer.
`default_nettype none

module ppk_fifo
    import ppk_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire texel_t wr_data,
    input  wire logic   pop,
    output texel_t      rd_data,
    output fifo_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    texel_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.valid = (count_reg != '0);
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppk_back.sv
// Back end: shifts texels into the 64-bit word and holds the output register.
`default_nettype none

module ppk_back
    import ppk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tex_valid,
    input  wire texel_t            texel,
    output logic                   tex_pop,
    output logic                   word_valid,
    output logic [WORD_W-1:0]      word,
    output logic                   word_last,
    input  wire logic              word_ready
);

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              ovalid_reg;
    logic [WORD_W-1:0] oword_reg;
    logic              olast_reg;

    logic [FILL_W:0]   total;
    logic [FILL_W:0]   shamt;
    logic [95:0]       wide;
    logic              emit;
    logic [WORD_W-1:0] emit_word;

    assign tex_pop = tex_valid && (!ovalid_reg || word_ready);

    // texel lands just below the filled bits of a 96-bit window
    assign total = {1'b0, fill_reg} + {1'b0, texel.len};
    assign shamt = 7'd96 - total;
    assign wide  = {acc_reg, 32'd0} | ({64'd0, texel.bits} << shamt);

    always_comb
    begin
        emit      = 1'b0;
        emit_word = wide[95:32];
        acc_next  = wide[95:32];
        fill_next = total[FILL_W-1:0];
        if (total[FILL_W])
        begin
            // word complete; any spill starts the next one
            emit     = 1'b1;
            acc_next = {wide[31:0], 32'd0};
        end
        if (texel.last)
        begin
            if (fill_next != '0)
                emit = 1'b1;
            acc_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            fill_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (tex_pop)
            begin
                acc_reg  <= acc_next;
                fill_reg <= fill_next;
            end
            if (tex_pop && emit)
                ovalid_reg <= 1'b1;
            else if (word_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tex_pop && emit)
        begin
            oword_reg <= emit_word;
            olast_reg <= texel.last;
        end
    end

    assign word_valid = ovalid_reg;
    assign word       = oword_reg;
    assign word_last  = olast_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pixel_format_packer.sv
// Top level of the pixel format packer: converter, texel queue, word packer.
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------------
//  pixels  | s_tvalid s_tready s_tdata s_tlast| ch0..ch3, tlast = last_pixel
//  words   | m_tvalid m_tready m_tdata m_tlast| packed_word, tlast = last_word
//  config  | cfg_we cfg_index cfg_data        | 0 format, 1 size, 2 channel count
//
// One pixel per cycle while the queue is not full; conversion and queue write share
// the input cycle. The packer drains one texel per cycle, unless the output stalls,
// through a 96-bit window shift; a word is loaded into the output register at the edge
// its last texel leaves the queue; every texel passes through the queue registers first.
// Reset clears the word, fill count, queue and output valid at once.
// A stalled output only stops the packer; pixels keep entering until the queue fills.
`default_nettype none

module pixel_format_packer
    import ppk_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // ch0 [7:0], ch1, ch2, ch3 [31:24]
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [WORD_W-1:0]      m_tdata,   // packed_word
    output logic                   m_tlast,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    texel_t     tex_in, tex_out;
    fifo_stat_t fstat;
    logic       push, pop;

    assign s_tready = !fstat.full;
    assign push     = s_tvalid && s_tready;

    ppk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (s_tdata),
        .pix_last  (s_tlast),
        .texel     (tex_in)
    );

    ppk_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (tex_in),
        .pop     (pop),
        .rd_data (tex_out),
        .stat    (fstat)
    );

    ppk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tex_valid  (fstat.valid),
        .texel      (tex_out),
        .tex_pop    (pop),
        .word_valid (m_tvalid),
        .word       (m_tdata),
        .word_last  (m_tlast),
        .word_ready (m_tready)
    );

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> fstat.valid)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && !m_tready) |-> !pop)
        else $error("packer advanced while output transfer stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fstat.full && !pop) |=> !s_tready)
        else $error("queue lost full state without a pop");

    assert property (@(posedge clk) disable iff (!rst_n) !(fstat.full && !fstat.valid))
        else $error("queue both full and empty");

endmodule

`default_nettype wire
